@@ design/pmcv_pkg.sv @@
// shared types, constants and helpers for the max communication volume block
`default_nettype none
package pmcv_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int VOLUME_BITS = 32;
  localparam int BLK_W       = $clog2(MAX_BLOCKS);
  localparam int FIELD_W     = 6;
  localparam int CNT_W       = 7;
  localparam int CFG_W       = 7;
  localparam int OUT_W       = 32;

  typedef struct packed {
    logic [FIELD_W-1:0] source_block;
    logic [FIELD_W-1:0] nbr_block;
    logic               has_edge;
    logic               node_last;
    logic               graph_last;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] max_volume;
    logic             saturated;
  } result_t;

  // node close request handed from the scan stage to the volume update stage
  typedef struct packed {
    logic             close;
    logic             graph_last;
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] count;
  } close_req_t;

  typedef struct packed {
    logic fire;
    logic pending;
  } acc_status_t;

  // clamp the running maximum to the output width
  function automatic result_t make_result(logic [VOLUME_BITS-1:0] m, logic s);
    logic [63:0] m64;
    result_t     r;
    m64 = 64'(m);
    if (m64 > 64'h0000_0000_FFFF_FFFF) begin
      r.max_volume = '1;
      r.saturated  = 1'b1;
    end else begin
      r.max_volume = m64[OUT_W-1:0];
      r.saturated  = s;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/partition_max_comm_volume.sv @@
// top level of the streaming maximum communication volume block
//
// item channel: one adjacency entry per beat (item_valid / item_stall), grouped
//   by node; node_last closes a node, graph_last closes node and graph
// result channel: one beat per graph (result_valid / result_stall) carrying the
//   largest block volume and the saturation flag
// cfg channel: cfg_valid / cfg_ready writes block_count; ready is always high,
//   writes are meant to land while no graph is in flight
// throughput: one item per cycle while item_stall is low; the per-node work is a
//   mask test in the scan stage and one read-modify-write of the block volume ram
//   at node end, with a same-block write forwarded into the next read
// result path: the graph's last item passes the update stage register and then
//   the output register, held back only while a held result blocks that update
// stall: items keep flowing while a result waits in the output register; the
//   item side stalls only when the next graph's result is ready to leave and
//   the output register is still held
// reset: block_count returns to 2, volumes, maximum and flags are cleared at
//   once through per-entry valid bits, so there is no clearing pass
`default_nettype none
module partition_max_comm_volume (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // adjacency entries
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire pmcv_pkg::item_t            item,
  // per-graph result
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output pmcv_pkg::result_t               result,
  // block_count register write
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [pmcv_pkg::CFG_W-1:0] cfg_data
);

  logic [pmcv_pkg::CFG_W-1:0] block_count;
  logic [pmcv_pkg::CFG_W-1:0] blk_limit;
  logic                       advance;
  logic                       accept;
  pmcv_pkg::close_req_t       req;
  pmcv_pkg::result_t          acc_result;
  pmcv_pkg::acc_status_t      acc_status;

  // block count clamped to 1..MAX_BLOCKS
  always_comb begin
    priority if (block_count == '0) begin
      blk_limit = pmcv_pkg::CFG_W'(1);
    end else if (block_count > pmcv_pkg::CFG_W'(pmcv_pkg::MAX_BLOCKS)) begin
      blk_limit = pmcv_pkg::CFG_W'(pmcv_pkg::MAX_BLOCKS);
    end else begin
      blk_limit = block_count;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= pmcv_pkg::CFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      block_count <= cfg_data;
    end
  end

  // freeze only when a second result would collide with a held one
  assign advance    = !(acc_status.pending && result_valid && result_stall);
  assign item_stall = !advance;
  assign accept     = item_valid && advance;

  pmcv_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .limit  (blk_limit),
    .req    (req)
  );

  pmcv_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .advance (advance),
    .req     (req),
    .result  (acc_result),
    .status  (acc_status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (acc_status.fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_status.fire) begin
      result <= acc_result;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    acc_status.fire |-> !(result_valid && result_stall))
    else $error("result register overwritten while held");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall && acc_status.pending))
    else $error("item side stalled without a held result");

  a_limit_range: assert property (@(posedge clk) disable iff (rst)
    (blk_limit != '0) && (blk_limit <= pmcv_pkg::CFG_W'(pmcv_pkg::MAX_BLOCKS)))
    else $error("block limit out of range");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(acc_status.fire))
    else $error("result beat without a closed graph");
`endif

endmodule
`default_nettype wire

@@ design/pmcv_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module pmcv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/pmcv_scan.sv @@
// per-node seen mask and distinct block count
`default_nettype none
module pmcv_scan (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire pmcv_pkg::item_t             item,
  input  wire logic [pmcv_pkg::CFG_W-1:0]  limit,
  output pmcv_pkg::close_req_t             req
);

  logic [pmcv_pkg::MAX_BLOCKS-1:0] mask;
  logic [pmcv_pkg::CNT_W-1:0]      count;
  logic [pmcv_pkg::CNT_W-1:0]      count_next;
  logic                            src_ok;
  logic                            tgt_ok;
  logic                            hit;
  logic                            fresh;
  logic                            closing;
  logic [pmcv_pkg::BLK_W-1:0]      src_idx;
  logic [pmcv_pkg::BLK_W-1:0]      tgt_idx;

  assign src_idx = item.source_block[pmcv_pkg::BLK_W-1:0];
  assign tgt_idx = item.nbr_block[pmcv_pkg::BLK_W-1:0];
  assign src_ok  = pmcv_pkg::CFG_W'(item.source_block) < limit;
  assign tgt_ok  = pmcv_pkg::CFG_W'(item.nbr_block) < limit;
  assign hit     = item.has_edge && src_ok && tgt_ok &&
                   (item.nbr_block != item.source_block);
  assign fresh   = hit && !mask[tgt_idx];
  assign count_next = count + pmcv_pkg::CNT_W'(fresh);
  assign closing = item.node_last || item.graph_last;

  always_comb begin
    req.close      = closing && src_ok;
    req.graph_last = item.graph_last;
    req.blk        = src_idx;
    req.count      = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask  <= '0;
      count <= '0;
    end else if (accept) begin
      if (closing) begin
        mask  <= '0;
        count <= '0;
      end else begin
        if (fresh) begin
          mask[tgt_idx] <= 1'b1;
        end
        count <= count_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/pmcv_accum.sv @@
// block volume read-modify-write, running maximum and saturation flag
`default_nettype none
module pmcv_accum (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic                  advance,
  input  wire pmcv_pkg::close_req_t  req,
  output pmcv_pkg::result_t          result,
  output pmcv_pkg::acc_status_t      status
);

  logic                                 s1_valid;
  pmcv_pkg::close_req_t                 s1_req;
  logic                                 s1_fwd;
  logic [pmcv_pkg::VOLUME_BITS-1:0]     s1_fwd_val;
  logic                                 s1_base_valid;
  logic [pmcv_pkg::MAX_BLOCKS-1:0]      vbits;
  logic [pmcv_pkg::VOLUME_BITS-1:0]     running_max;
  logic                                 sat_flag;

  logic [pmcv_pkg::VOLUME_BITS-1:0] rd_data;
  logic [pmcv_pkg::VOLUME_BITS-1:0] old_vol;
  logic [pmcv_pkg::VOLUME_BITS:0]   sum;
  logic [pmcv_pkg::VOLUME_BITS-1:0] new_vol;
  logic                             ovf;
  logic                             wr;
  logic                             fire;
  logic [pmcv_pkg::VOLUME_BITS-1:0] max_next;
  logic                             sat_next;

  pmcv_ram #(
    .WIDTH (pmcv_pkg::VOLUME_BITS),
    .DEPTH (pmcv_pkg::MAX_BLOCKS)
  ) u_vol_ram (
    .clk     (clk),
    .wr_en   (wr),
    .wr_addr (s1_req.blk),
    .wr_data (new_vol),
    .rd_en   (accept && req.close),
    .rd_addr (req.blk),
    .rd_data (rd_data)
  );

  // entries not written since the last graph read as zero
  assign old_vol = s1_fwd ? s1_fwd_val : (s1_base_valid ? rd_data : '0);
  assign sum     = {1'b0, old_vol} + (pmcv_pkg::VOLUME_BITS+1)'(s1_req.count);
  assign ovf     = sum[pmcv_pkg::VOLUME_BITS];
  assign new_vol = ovf ? '1 : sum[pmcv_pkg::VOLUME_BITS-1:0];
  assign wr      = s1_valid && s1_req.close && advance;
  assign fire    = s1_valid && s1_req.graph_last && advance;

  always_comb begin
    max_next = running_max;
    if (wr && (new_vol > running_max)) begin
      max_next = new_vol;
    end
    sat_next = sat_flag || (wr && ovf);
  end

  assign result         = pmcv_pkg::make_result(max_next, sat_next);
  assign status.fire    = fire;
  assign status.pending = s1_valid && s1_req.graph_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      vbits       <= '0;
      running_max <= '0;
      sat_flag    <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid <= accept;
      end
      if (fire) begin
        vbits       <= '0;
        running_max <= '0;
        sat_flag    <= 1'b0;
      end else begin
        running_max <= max_next;
        sat_flag    <= sat_next;
        if (wr) begin
          vbits[s1_req.blk] <= 1'b1;
        end
      end
    end
  end

  // payload of the update stage, with forwarding of a same-block write
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_req        <= req;
      s1_fwd        <= wr && !s1_req.graph_last && (s1_req.blk == req.blk);
      s1_fwd_val    <= new_vol;
      s1_base_valid <= vbits[req.blk] && !fire;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/partition_max_comm_volume_tb.sv @@
// self-checking testbench for the streaming maximum communication volume block
`default_nettype none
module partition_max_comm_volume_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // generous ceiling for the watchdog
  localparam int CYCLE_LIMIT = 200000;
  // minimum items queued per random phase, eight phases after the directed part
  localparam int PHASE_ITEMS = 192;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // item channel, driven at the rising edge
  logic              item_valid = 1'b0;
  logic              item_stall;
  pmcv_pkg::item_t   item_beat  = '0;
  // result channel
  logic              result_valid;
  logic              result_stall = 1'b0;
  pmcv_pkg::result_t result_beat;
  // block_count write channel
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [pmcv_pkg::CFG_W-1:0] cfg_data  = '0;

  // adjacency entries waiting to be driven, graph results waiting to arrive
  pmcv_pkg::item_t   entry_queue [$];
  pmcv_pkg::result_t volume_expect [$];

  // bookkeeping
  int n_sent     = 0;
  int n_taken    = 0;
  int n_checked  = 0;
  int n_writes   = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // idle control; the percentages are set per phase by the stimulus process
  int idle_pct  = 0;
  int stall_pct = 0;
  int send_gap  = 0;
  int hold_gap  = 0;

  int phase_blocks [8] = '{64, 1, 0, 127, 7, 33, 2, 64};

  // volume tally: own copy of the block's state and its register
  logic [pmcv_pkg::CFG_W-1:0]       blocks_cfg = 7'd2;
  logic [pmcv_pkg::MAX_BLOCKS-1:0]  reach_mask;
  logic [pmcv_pkg::CNT_W-1:0]       reach_cnt;
  logic [pmcv_pkg::VOLUME_BITS-1:0] block_vol [pmcv_pkg::MAX_BLOCKS];
  logic [pmcv_pkg::VOLUME_BITS-1:0] vol_max;
  logic                             vol_sat;

  partition_max_comm_volume dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_beat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // wipe the tally, as reset and every graph end do in the block
  function automatic void reset_tally();
    reach_mask = '0;
    reach_cnt  = '0;
    foreach (block_vol[i]) block_vol[i] = '0;
    vol_max = '0;
    vol_sat = 1'b0;
  endfunction

  // fold one accepted entry into the tally; returns 1 when the graph closes
  function automatic bit absorb_entry(input pmcv_pkg::item_t it,
                                      output pmcv_pkg::result_t res);
    int                             lim;
    logic [pmcv_pkg::VOLUME_BITS:0] sum;
    // register value clamped to 1..MAX_BLOCKS
    if (blocks_cfg == 0) lim = 1;
    else if (blocks_cfg > pmcv_pkg::MAX_BLOCKS) lim = pmcv_pkg::MAX_BLOCKS;
    else lim = int'(blocks_cfg);
    res = '0;
    // a new foreign block reached by the current node
    if (it.has_edge && it.source_block < lim && it.nbr_block < lim &&
        it.nbr_block != it.source_block && !reach_mask[it.nbr_block]) begin
      reach_mask[it.nbr_block] = 1'b1;
      reach_cnt = reach_cnt + 1'b1;
    end
    // node end, forced by graph end as well; the closing entry names the block
    if (it.node_last || it.graph_last) begin
      if (it.source_block < lim) begin
        sum = {1'b0, block_vol[it.source_block]} + reach_cnt;
        if (sum[pmcv_pkg::VOLUME_BITS]) begin
          block_vol[it.source_block] = '1;
          vol_sat = 1'b1;
        end else begin
          block_vol[it.source_block] = sum[pmcv_pkg::VOLUME_BITS-1:0];
        end
        if (block_vol[it.source_block] > vol_max) vol_max = block_vol[it.source_block];
      end
      reach_mask = '0;
      reach_cnt  = '0;
    end
    if (!it.graph_last) return 1'b0;
    // volume width equals the output width, so no output clamp applies here
    res.max_volume = vol_max;
    res.saturated  = vol_sat;
    reset_tally();
    return 1'b1;
  endfunction

  // item driver: loads the next entry once the current beat has gone,
  // holds it unchanged while stalled, and inserts random idle bursts
  always @(posedge clk) begin : drive_items
    pmcv_pkg::result_t r;
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // register write seen on the wire; only happens with no graph in flight
      if (cfg_valid && cfg_ready) blocks_cfg = cfg_data;
      if (item_valid && !item_stall) begin
        if (absorb_entry(item_beat, r)) volume_expect.push_back(r);
        n_taken++;
      end
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (entry_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          item_beat  <= entry_queue.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
          if (entry_queue.size() > 0) send_gap = $urandom_range(9);
        end
      end
    end
  end

  // result monitor: checks each beat against the oldest expected result and
  // throws random stall bursts at the result channel
  always @(posedge clk) begin : check_results
    pmcv_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      hold_gap = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (volume_expect.size() == 0) begin
          $error("unexpected result beat: max_volume %0d saturated %0d",
                 result_beat.max_volume, result_beat.saturated);
          fail_count++;
        end else begin
          want = volume_expect.pop_front();
          n_checked++;
          if (result_beat.max_volume !== want.max_volume) begin
            $error("max_volume: expected %0d, actual %0d",
                   want.max_volume, result_beat.max_volume);
            fail_count++;
          end
          if (result_beat.saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d",
                   want.saturated, result_beat.saturated);
            fail_count++;
          end
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        result_stall <= 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
        hold_gap = $urandom_range(9);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_entry(input int sb, input int tb, input bit he, input bit nl,
                            input bit gl);
    pmcv_pkg::item_t e;
    e.source_block = sb[pmcv_pkg::FIELD_W-1:0];
    e.nbr_block    = tb[pmcv_pkg::FIELD_W-1:0];
    e.has_edge     = he;
    e.node_last    = nl;
    e.graph_last   = gl;
    entry_queue.push_back(e);
    n_sent++;
  endtask

  // mostly in range, now and then any block
  function automatic int pick_block(input int lim);
    if ($urandom_range(9) == 0) return $urandom_range(63);
    return $urandom_range(lim - 1);
  endfunction

  // well-formed graph: nodes of grouped entries, then one of three endings
  task automatic push_graph(input int lim);
    int nodes, len, src, ending;
    bit last;
    nodes  = $urandom_range(0, 5);
    ending = $urandom_range(2);
    for (int n = 0; n < nodes; n++) begin
      src = pick_block(lim);
      // now and then a long node so that most foreign blocks get reached
      len = ($urandom_range(19) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        last = (k == len - 1);
        push_entry(src, pick_block(lim), $urandom_range(15) != 0, last,
                   last && n == nodes - 1 && ending == 0);
      end
    end
    if (nodes == 0 || ending == 1) begin
      // bare end marker, may or may not also claim a node end
      push_entry(pick_block(lim), $urandom_range(63), 1'b0, 1'($urandom_range(1)),
                 1'b1);
    end else if (ending == 2) begin
      // graph ends in the middle of a node
      src = pick_block(lim);
      len = $urandom_range(1, 4);
      for (int k = 0; k < len; k++)
        push_entry(src, pick_block(lim), 1'b1, 1'b0, k == len - 1);
    end
  endtask

  // broken grouping: every field but graph_last random, closed by a graph end
  task automatic push_noise();
    int len;
    len = $urandom_range(1, 12);
    for (int k = 0; k < len; k++)
      push_entry($urandom_range(63), $urandom_range(63), 1'($urandom_range(1)),
                 1'($urandom_range(1)), k == len - 1);
  endtask

  // hold off until every entry is taken and every graph result has come back,
  // then let the result path settle
  task automatic drain();
    while (n_taken != n_sent || volume_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_blocks(input int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[pmcv_pkg::CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  initial begin : run_graphs
    int lim, phase_end;
    reset_tally();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset value of two blocks
    idle_pct  = 30;
    stall_pct = 30;
    push_entry(0, 1, 1'b1, 1'b1, 1'b0);   // node in block 0 reaches block 1
    push_entry(1, 1, 1'b1, 1'b0, 1'b0);   // own block, not counted
    push_entry(1, 0, 1'b1, 1'b0, 1'b0);
    push_entry(1, 0, 1'b1, 1'b1, 1'b0);   // repeated target counts once
    push_entry(0, 5, 1'b1, 1'b1, 1'b0);   // target beyond block count
    push_entry(5, 0, 1'b1, 1'b1, 1'b0);   // source beyond block count
    push_entry(0, 0, 1'b0, 1'b0, 1'b1);   // bare marker ends the graph
    drain();

    // directed part at the full block count, field extremes
    write_blocks(64);
    push_entry(63, 0, 1'b1, 1'b0, 1'b0);
    push_entry(63, 62, 1'b1, 1'b0, 1'b0);
    push_entry(63, 62, 1'b1, 1'b0, 1'b0);
    push_entry(63, 63, 1'b1, 1'b1, 1'b0);  // closing entry on own block
    push_entry(0, 63, 1'b1, 1'b0, 1'b0);
    push_entry(0, 1, 1'b1, 1'b0, 1'b1);    // graph end without node end
    push_entry(0, 0, 1'b0, 1'b0, 1'b1);    // empty graph
    push_entry(10, 20, 1'b1, 1'b0, 1'b0);
    push_entry(10, 30, 1'b0, 1'b1, 1'b0);  // bare marker closes a node
    push_entry(63, 63, 1'b1, 1'b1, 1'b1);  // node end and graph end together
    drain();

    // random phases, one register setting each; each phase drains fully
    phase_blocks[6] = $urandom_range(2, 63);
    for (int p = 0; p < 8; p++) begin
      write_blocks(phase_blocks[p]);
      if (phase_blocks[p] == 0) lim = 1;
      else if (phase_blocks[p] > pmcv_pkg::MAX_BLOCKS) lim = pmcv_pkg::MAX_BLOCKS;
      else lim = phase_blocks[p];
      // alternate stretches without sender or receiver idling; none at the end
      idle_pct  = (p == 7 || p % 3 == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = (p == 7 || p % 3 == 1) ? 0 : $urandom_range(5, 40);
      phase_end = n_sent + PHASE_ITEMS;
      while (n_sent < phase_end) begin
        if ($urandom_range(99) < 15) push_noise();
        else push_graph(lim);
      end
      drain();
    end

    repeat (6) @(posedge clk);
    $display("checked %0d graph results from %0d adjacency entries", n_checked, n_taken);
    $display("block_count written %0d times, covering 0, 1, 64, 127 and mid values",
             n_writes);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
design/pmcv_pkg.sv
design/pmcv_ram.sv
design/pmcv_scan.sv
design/pmcv_accum.sv
design/partition_max_comm_volume.sv
tb/sv/partition_max_comm_volume_tb.sv
